FILE: design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared sizes, operation codes and transfer payload types for the LRU
// key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    // store geometry
    localparam int ENTRIES     = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;

    // derived widths
    localparam int IDX_WIDTH   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_WIDTH  = IDX_WIDTH;
    localparam int CNT_WIDTH   = $clog2(ENTRIES + 1);
    localparam int ENTRY_WIDTH = KEY_WIDTH + VALUE_WIDTH;

    // capacity register
    localparam int CAP_WIDTH = 5;
    localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = CAP_WIDTH'(16);

    // operation codes
    typedef logic [1:0] op_t;
    localparam op_t OP_GET    = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_UPDATE = 2'd2;
    localparam op_t OP_ERASE  = 2'd3;

    // request payload
    typedef struct packed {
        op_t                    operation;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } req_t;

    // response payload
    typedef struct packed {
        logic                   found;
        logic [VALUE_WIDTH-1:0] read_value;
    } resp_t;

endpackage

`default_nettype wire

FILE: design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries operation, key and value.
//   resp channel (resp_valid/resp_ready/resp) returns found and read_value,
//   exactly one response per request, in request order.
//   cfg_wr_en/cfg_wr_data write the capacity register at any edge; write it
//   only while no request is in flight.
// Timing:
//   one request is handled at a time; the sequencer reads all ENTRIES slots
//   of the key/value RAM one per cycle, compares each slot in the cycle
//   after its read, then in the update state updates the valid bits, the
//   recency ranks and the RAM once the response register is free. A new
//   request is taken only after that update; the scan length is set by the
//   single RAM read port used in the key scan.
// Reset:
//   all slots invalid, count zero, capacity 16. No clearing pass is needed.
// Stall:
//   the response sits in an output register; a new request may be taken and
//   scanned while it waits, and the update cycle holds until the register
//   frees.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lkv_pkg::CAP_WIDTH-1:0] cfg_wr_data,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire lkv_pkg::req_t               req,
    output logic                             resp_valid,
    input  wire logic                        resp_ready,
    output lkv_pkg::resp_t                   resp
);

    import lkv_pkg::*;

    localparam int SCAN_WIDTH = $clog2(ENTRIES + 1);
    localparam int CMP_WIDTH  = (CNT_WIDTH > CAP_WIDTH) ? CNT_WIDTH : CAP_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;

    // control and status registers
    logic [CAP_WIDTH-1:0]  cap_reg;
    logic [CNT_WIDTH-1:0]  count_reg, count_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [RANK_WIDTH-1:0] rank_reg [ENTRIES];
    logic [RANK_WIDTH-1:0] rank_next [ENTRIES];

    // scan registers
    logic [SCAN_WIDTH-1:0] scan_reg, scan_next;
    logic                  pend_reg, pend_next;
    logic [IDX_WIDTH-1:0]  cmp_reg, cmp_next;
    logic                  hit_reg, hit_next;
    logic [IDX_WIDTH-1:0]  hit_idx_reg, hit_idx_next;
    logic [VALUE_WIDTH-1:0] hit_val_reg, hit_val_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_WIDTH-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_WIDTH-1:0]  lru_idx_reg, lru_idx_next;

    // request and response registers
    req_t  req_reg;
    resp_t resp_reg, resp_next;
    logic  resp_valid_reg, resp_valid_next;

    // ram signals
    logic                   ram_we;
    logic [IDX_WIDTH-1:0]   ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [IDX_WIDTH-1:0]   ram_raddr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;

    // update controls
    logic                  req_xfer;
    logic                  upd_go;
    logic                  touch_en;
    logic [IDX_WIDTH-1:0]  touch_idx;
    logic [RANK_WIDTH-1:0] touch_rank;
    logic                  age_all_en;
    logic                  erase_en;
    logic [CMP_WIDTH-1:0]  eff_cap;
    logic [CNT_WIDTH-1:0]  last_rank;

    assign req_ready  = (state_reg == S_IDLE);
    assign req_xfer   = req_valid && req_ready;
    assign upd_go     = !resp_valid_reg || resp_ready;
    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;
    assign rd_key     = ram_rdata[ENTRY_WIDTH-1:VALUE_WIDTH];
    assign rd_val     = ram_rdata[VALUE_WIDTH-1:0];
    assign last_rank  = count_reg - CNT_WIDTH'(1);
    assign touch_rank = rank_reg[touch_idx];

    // effective capacity: zero acts as one, clipped at the store size
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            eff_cap = CMP_WIDTH'(1);
        end
        else if (CMP_WIDTH'(cap_reg) > CMP_WIDTH'(ENTRIES))
        begin
            eff_cap = CMP_WIDTH'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_WIDTH'(cap_reg);
        end
    end

    // key/value storage
    lkv_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer and scan
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        pend_next       = 1'b0;
        cmp_next        = cmp_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_val_next    = hit_val_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        lru_idx_next    = lru_idx_reg;
        ram_re          = 1'b0;
        ram_raddr       = scan_reg[IDX_WIDTH-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next      = S_SCAN;
                    scan_next       = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                // issue one slot read a cycle
                if (scan_reg != SCAN_WIDTH'(ENTRIES))
                begin
                    ram_re    = 1'b1;
                    scan_next = scan_reg + SCAN_WIDTH'(1);
                    pend_next = 1'b1;
                    cmp_next  = scan_reg[IDX_WIDTH-1:0];
                end
                // check the slot read last cycle
                if (pend_reg)
                begin
                    if (valid_reg[cmp_reg] && rd_key == req_reg.key && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_reg;
                        hit_val_next = rd_val;
                    end
                    if (!valid_reg[cmp_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_reg;
                    end
                    if (valid_reg[cmp_reg] && CNT_WIDTH'(rank_reg[cmp_reg]) == last_rank)
                    begin
                        lru_idx_next = cmp_reg;
                    end
                    if (scan_reg == SCAN_WIDTH'(ENTRIES))
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_UPD:
            begin
                if (upd_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // operation decode for the update cycle
    always_comb
    begin
        count_next       = count_reg;
        valid_next       = valid_reg;
        ram_we           = 1'b0;
        ram_waddr        = hit_idx_reg;
        ram_wdata        = {req_reg.key, req_reg.value};
        touch_en         = 1'b0;
        touch_idx        = hit_idx_reg;
        age_all_en       = 1'b0;
        erase_en         = 1'b0;
        resp_next        = resp_reg;
        resp_valid_next  = resp_valid_reg && !resp_ready;

        if (state_reg == S_UPD && upd_go)
        begin
            resp_valid_next      = 1'b1;
            resp_next.found      = hit_reg;
            resp_next.read_value = '0;
            unique case (req_reg.operation)
                OP_GET:
                begin
                    if (hit_reg)
                    begin
                        resp_next.read_value = hit_val_reg;
                        touch_en             = 1'b1;
                    end
                end
                OP_UPDATE:
                begin
                    if (hit_reg)
                    begin
                        ram_we   = 1'b1;
                        touch_en = 1'b1;
                    end
                end
                OP_INSERT:
                begin
                    resp_next.found = 1'b1;
                    ram_we          = 1'b1;
                    priority if (hit_reg)
                    begin
                        touch_en = 1'b1;
                    end
                    else if (CMP_WIDTH'(count_reg) < eff_cap)
                    begin
                        // fill the lowest free slot
                        ram_waddr               = free_idx_reg;
                        age_all_en              = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        count_next              = count_reg + CNT_WIDTH'(1);
                    end
                    else
                    begin
                        // evict the least recent entry
                        ram_waddr = lru_idx_reg;
                        touch_idx = lru_idx_reg;
                        touch_en  = 1'b1;
                    end
                end
                OP_ERASE:
                begin
                    if (hit_reg)
                    begin
                        erase_en               = 1'b1;
                        valid_next[hit_idx_reg] = 1'b0;
                        count_next             = count_reg - CNT_WIDTH'(1);
                    end
                end
                default:
                begin
                    resp_next.found = hit_reg;
                end
            endcase
        end
    end

    // recency rank update, one independent rule per slot
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (touch_en)
            begin
                if (IDX_WIDTH'(i) == touch_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && rank_reg[i] < touch_rank)
                begin
                    rank_next[i] = rank_reg[i] + RANK_WIDTH'(1);
                end
            end
            else if (age_all_en)
            begin
                if (IDX_WIDTH'(i) == free_idx_reg)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_WIDTH'(1);
                end
            end
            else if (erase_en)
            begin
                if (IDX_WIDTH'(i) == hit_idx_reg)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && rank_reg[i] > rank_reg[hit_idx_reg])
                begin
                    rank_next[i] = rank_reg[i] - RANK_WIDTH'(1);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= CAPACITY_RESET;
            count_reg      <= '0;
            valid_reg      <= '0;
            scan_reg       <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            resp_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            scan_reg       <= scan_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            resp_valid_reg <= resp_valid_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            req_reg <= req;
        end
        cmp_reg      <= cmp_next;
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        free_idx_reg <= free_idx_next;
        lru_idx_reg  <= lru_idx_next;
        resp_reg     <= resp_next;
    end

endmodule

`default_nettype wire

FILE: design/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// Generic simple dual-port RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cfg_wr_en,
    input wire logic [lkv_pkg::CAP_WIDTH-1:0] cfg_wr_data,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire lkv_pkg::req_t                 req,
    input wire logic                          resp_valid,
    input wire logic                          resp_ready,
    input wire lkv_pkg::resp_t                resp
);

    import lkv_pkg::*;

    // stalled response holds
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(resp))
        else $error("response changed while stalled");

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // only a get hit returns data
    a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp.read_value != '0 |-> resp.found)
        else $error("read value on a miss");

    // a response never follows its request transfer at once
    a_no_instant_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid) |-> !$past(req_valid && req_ready))
        else $error("response too soon after request transfer");

    // capacity writes land only while the block is idle
    a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |-> req_ready && !resp_valid && !$isunknown(cfg_wr_data))
        else $error("capacity written while a request is in flight");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .resp_valid  (resp_valid),
    .resp_ready  (resp_ready),
    .resp        (resp)
);

`default_nettype wire
